// File: design/sca_pkg.sv
// ----------------------------------------------------------------------------
// Sound channel allocator package
// Field widths, request and status codes, and types shared by the allocator.
// ----------------------------------------------------------------------------
package sca_pkg;

   localparam int SOUND_W    = 7;
   localparam int CHAN_REQ_W = 3;
   localparam int NOTE_W     = 6;
   localparam int POS_W      = 5;
   localparam int KEY_W      = 6;
   localparam int VOL_W      = 3;
   localparam int STATUS_W   = 3;
   localparam int USED_W     = 2;
   localparam int REPORTED   = 4;

   localparam logic signed [SOUND_W-1:0]    IDLE_SOUND      = -7'sd1;
   localparam logic signed [SOUND_W-1:0]    SOUND_STOP      = -7'sd1;
   localparam logic signed [SOUND_W-1:0]    SOUND_RELEASE   = -7'sd2;
   localparam logic signed [CHAN_REQ_W-1:0] CHAN_ALL        = -3'sd2;
   localparam logic signed [CHAN_REQ_W-1:0] CHAN_AUTO_LOW   = -3'sd2;
   localparam logic [KEY_W-1:0]             KEY_AFTER_START = 6'd24;

   typedef enum logic [STATUS_W-1:0] {
      ST_REJECTED  = 3'd0,
      ST_NO_EFFECT = 3'd1,
      ST_STOPPED   = 3'd2,
      ST_RELEASED  = 3'd3,
      ST_STARTED   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      OP_REJECT,
      OP_NONE,
      OP_STOP_ALL,
      OP_STOP_CHAN,
      OP_RELEASE,
      OP_START
   } op_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_APPLY,
      S_RESP
   } state_type;

   // One write to the channel file per cycle.
   typedef struct packed {
      logic stop;
      logic release_loop;
      logic start;
   } wr_cmd_type;

endpackage

// File: design/sca_if.sv
// ----------------------------------------------------------------------------
// Sound channel allocator channels
// Valid/ready request and response interfaces with their payloads.
// ----------------------------------------------------------------------------
interface sca_req_if
   import sca_pkg::*;
   ();
   logic                         valid;
   logic                         ready;
   logic signed [SOUND_W-1:0]    sound_request;
   logic signed [CHAN_REQ_W-1:0] channel_request;
   logic signed [NOTE_W-1:0]     start_note;

   modport source (output valid, sound_request, channel_request, start_note,
                   input ready);
   modport sink   (input valid, sound_request, channel_request, start_note,
                   output ready);
endinterface

interface sca_rsp_if
   import sca_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic [STATUS_W-1:0]       status;
   logic [USED_W-1:0]         channel_used;
   logic signed [SOUND_W-1:0] chan0_sound;
   logic signed [SOUND_W-1:0] chan1_sound;
   logic signed [SOUND_W-1:0] chan2_sound;
   logic signed [SOUND_W-1:0] chan3_sound;

   modport source (output valid, status, channel_used, chan0_sound, chan1_sound,
                   chan2_sound, chan3_sound, input ready);
   modport sink   (input valid, status, channel_used, chan0_sound, chan1_sound,
                   chan2_sound, chan3_sound, output ready);
endinterface

// File: design/sca_chan_file.sv
// ----------------------------------------------------------------------------
// Sound channel allocator channel file
// Per-channel playback records with one indexed read and one indexed write.
// ----------------------------------------------------------------------------
module sca_chan_file
   import sca_pkg::*;
#(
   parameter int CHANNEL_COUNT = 4,
   parameter int IDX_W         = 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [IDX_W-1:0]          rd_idx,
   output logic signed [SOUND_W-1:0] rd_sound,
   input  wr_cmd_type                wr_cmd,
   input  logic [IDX_W-1:0]          wr_idx,
   input  logic signed [SOUND_W-1:0] wr_sound,
   input  logic [POS_W-1:0]          wr_note,
   output logic signed [SOUND_W-1:0] sounds [CHANNEL_COUNT]
);

   logic signed [SOUND_W-1:0] sound_ff  [CHANNEL_COUNT];
   logic [POS_W-1:0]          pos_ff    [CHANNEL_COUNT];
   logic                      loop_ff   [CHANNEL_COUNT];
   logic                      music_ff  [CHANNEL_COUNT];
   logic [KEY_W-1:0]          key_ff    [CHANNEL_COUNT];
   logic [VOL_W-1:0]          vol_ff    [CHANNEL_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNEL_COUNT; c++) begin
            sound_ff[c] <= IDLE_SOUND;
            pos_ff[c]   <= '0;
            loop_ff[c]  <= 1'b1;
            music_ff[c] <= 1'b0;
            key_ff[c]   <= '0;
            vol_ff[c]   <= '0;
         end
      end else if (wr_cmd.start) begin
         sound_ff[wr_idx] <= wr_sound;
         pos_ff[wr_idx]   <= wr_note;
         loop_ff[wr_idx]  <= 1'b1;
         music_ff[wr_idx] <= 1'b0;
         key_ff[wr_idx]   <= KEY_AFTER_START;
         vol_ff[wr_idx]   <= '0;
      end else if (wr_cmd.stop) begin
         sound_ff[wr_idx] <= IDLE_SOUND;
      end else if (wr_cmd.release_loop) begin
         loop_ff[wr_idx] <= 1'b0;
      end
   end

   assign rd_sound = sound_ff[rd_idx];
   assign sounds   = sound_ff;

endmodule

// File: design/sca_scan.sv
// ----------------------------------------------------------------------------
// Sound channel allocator scan unit
// Shared comparator: one channel per cycle while step is high; tracks the pick.
// ----------------------------------------------------------------------------
module sca_scan
   import sca_pkg::*;
#(
   parameter int IDX_W = 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      clear,
   input  logic                      step,
   input  logic [IDX_W-1:0]          idx,
   input  logic signed [SOUND_W-1:0] cur_sound,
   input  logic signed [SOUND_W-1:0] req_sound,
   output logic                      match,
   output logic [IDX_W-1:0]          pick
);

   logic                      found_ff, found_in;
   logic [IDX_W-1:0]          first_ff, first_in;
   logic [IDX_W-1:0]          min_idx_ff, min_idx_in;
   logic signed [SOUND_W-1:0] min_val_ff, min_val_in;
   logic                      free_or_same;

   assign match        = (cur_sound == req_sound);
   assign free_or_same = match || (cur_sound == IDLE_SOUND);

   always_comb begin
      found_in   = found_ff;
      first_in   = first_ff;
      min_idx_in = min_idx_ff;
      min_val_in = min_val_ff;
      if (clear) begin
         found_in = 1'b0;
      end else if (step) begin
         // The first idle or same-sound channel wins.
         if (!found_ff && free_or_same) begin
            found_in = 1'b1;
            first_in = idx;
         end
         // Strict compare keeps the lowest channel among equal sounds.
         if (idx == '0 || cur_sound < min_val_ff) begin
            min_idx_in = idx;
            min_val_in = cur_sound;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      first_ff   <= first_in;
      min_idx_ff <= min_idx_in;
      min_val_ff <= min_val_in;
   end

   assign pick = found_ff ? first_ff : min_idx_ff;

endmodule

// File: design/sound_channel_allocator.sv
// ----------------------------------------------------------------------------
// Sound channel allocator
// Assigns sounds to playback channels, one request at a time.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Moves                                   Accepted when
// req       in   sound_request, channel_request, note    req.valid && req.ready
// rsp       out  status, channel_used, chan0..3_sound    rsp.valid && rsp.ready
//
// A start scans every channel in turn through the single shared comparator,
// then writes the picked channel and responds. A stop on all channels scans
// and responds; stop-channel and release write the named channel and respond;
// requests rejected or of no effect at decode respond with no scan or write.
// The response holds until taken; the next request can be accepted in the
// cycle after it is taken. Reset idles every channel and needs no clearing pass.
//
module sound_channel_allocator
   import sca_pkg::*;
#(
   parameter int CHANNEL_COUNT = 4,
   parameter int SOUND_COUNT   = 64
) (
   input logic       clock,
   input logic       reset,
   sca_req_if.sink   req,
   sca_rsp_if.source rsp
);

   localparam int IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

   // Sequencer state and the captured request.
   state_type                    state_ff, state_in;
   op_type                       op_ff, op_in;
   logic signed [SOUND_W-1:0]    snd_ff, snd_in;
   logic signed [CHAN_REQ_W-1:0] chn_ff, chn_in;
   logic [POS_W-1:0]             note_ff, note_in;
   logic [IDX_W-1:0]             scan_idx_ff, scan_idx_in;
   logic                         hit_ff, hit_in;
   status_type                   status_ff, status_in;
   logic [IDX_W-1:0]             act_idx_ff, act_idx_in;

   logic                         accept;
   logic                         scan_last;
   op_type                       op_dec;
   logic                         snd_bad, chn_bad;
   logic [IDX_W-1:0]             named_idx;

   // Channel file and scan unit hookup.
   wr_cmd_type                   wr_cmd;
   logic [IDX_W-1:0]             wr_idx;
   logic signed [SOUND_W-1:0]    rd_sound;
   logic signed [SOUND_W-1:0]    sounds [CHANNEL_COUNT];
   logic signed [SOUND_W-1:0]    reported [REPORTED];
   logic                         scan_clear, scan_step, scan_match;
   logic [IDX_W-1:0]             scan_pick;

   sca_chan_file #(
      .CHANNEL_COUNT (CHANNEL_COUNT),
      .IDX_W         (IDX_W)
   ) u_chan_file (
      .clock    (clock),
      .reset    (reset),
      .rd_idx   (scan_idx_ff),
      .rd_sound (rd_sound),
      .wr_cmd   (wr_cmd),
      .wr_idx   (wr_idx),
      .wr_sound (snd_ff),
      .wr_note  (note_ff),
      .sounds   (sounds)
   );

   sca_scan #(
      .IDX_W (IDX_W)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .clear     (scan_clear),
      .step      (scan_step),
      .idx       (scan_idx_ff),
      .cur_sound (rd_sound),
      .req_sound (snd_ff),
      .match     (scan_match),
      .pick      (scan_pick)
   );

   assign accept    = req.valid && req.ready;
   assign scan_last = (scan_idx_ff == IDX_W'(CHANNEL_COUNT - 1));
   assign named_idx = IDX_W'($unsigned(chn_ff));

   // Request decode. A negative channel of -2 asks to stop a sound everywhere;
   // a stop or release with automatic channel choice does nothing.
   always_comb begin
      snd_bad = (req.sound_request < SOUND_RELEASE)
             || (int'(req.sound_request) >= SOUND_COUNT);
      chn_bad = (req.channel_request < CHAN_AUTO_LOW)
             || (int'(req.channel_request) >= CHANNEL_COUNT);
      if (snd_bad || chn_bad) begin
         op_dec = OP_REJECT;
      end else if (req.channel_request == CHAN_ALL) begin
         op_dec = req.sound_request[SOUND_W-1] ? OP_NONE : OP_STOP_ALL;
      end else if (req.sound_request == SOUND_STOP) begin
         op_dec = req.channel_request[CHAN_REQ_W-1] ? OP_NONE : OP_STOP_CHAN;
      end else if (req.sound_request == SOUND_RELEASE) begin
         op_dec = req.channel_request[CHAN_REQ_W-1] ? OP_NONE : OP_RELEASE;
      end else begin
         op_dec = OP_START;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (op_dec)
                  OP_STOP_ALL, OP_START:    state_in = S_SCAN;
                  OP_STOP_CHAN, OP_RELEASE: state_in = S_APPLY;
                  default:                  state_in = S_RESP;
               endcase
            end
         end
         S_SCAN: begin
            if (scan_last) begin
               state_in = (op_ff == OP_START) ? S_APPLY : S_RESP;
            end
         end
         S_APPLY: state_in = S_RESP;
         S_RESP: begin
            if (rsp.ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Sequencer outputs: handshakes, scan control and channel file writes.
   always_comb begin
      req.ready  = (state_ff == S_IDLE);
      rsp.valid  = (state_ff == S_RESP);
      scan_clear = accept;
      scan_step  = 1'b0;
      wr_cmd     = '0;
      wr_idx     = scan_idx_ff;
      case (state_ff)
         S_SCAN: begin
            scan_step = 1'b1;
            // Copies of the sound go idle; a start rewrites its own pick later.
            wr_cmd.stop = scan_match;
         end
         S_APPLY: begin
            case (op_ff)
               OP_STOP_CHAN: begin
                  wr_cmd.stop = 1'b1;
                  wr_idx      = named_idx;
               end
               OP_RELEASE: begin
                  wr_cmd.release_loop = 1'b1;
                  wr_idx              = named_idx;
               end
               OP_START: begin
                  wr_cmd.start = 1'b1;
                  wr_idx       = chn_ff[CHAN_REQ_W-1] ? scan_pick : named_idx;
               end
               default: wr_cmd = '0;
            endcase
         end
         default: scan_step = 1'b0;
      endcase
   end

   // Captured request, scan position and result.
   always_comb begin
      op_in       = op_ff;
      snd_in      = snd_ff;
      chn_in      = chn_ff;
      note_in     = note_ff;
      scan_idx_in = scan_idx_ff;
      hit_in      = hit_ff;
      status_in   = status_ff;
      act_idx_in  = act_idx_ff;
      if (accept) begin
         op_in       = op_dec;
         snd_in      = req.sound_request;
         chn_in      = req.channel_request;
         note_in     = req.start_note[NOTE_W-1] ? '0 : req.start_note[POS_W-1:0];
         scan_idx_in = '0;
         hit_in      = 1'b0;
         act_idx_in  = '0;
         status_in   = (op_dec == OP_REJECT) ? ST_REJECTED : ST_NO_EFFECT;
      end else if (state_ff == S_SCAN) begin
         scan_idx_in = scan_idx_ff + IDX_W'(1);
         hit_in      = hit_ff || scan_match;
         if (scan_last && op_ff == OP_STOP_ALL) begin
            status_in = (hit_ff || scan_match) ? ST_STOPPED : ST_NO_EFFECT;
         end
      end else if (state_ff == S_APPLY) begin
         act_idx_in = wr_idx;
         case (op_ff)
            OP_STOP_CHAN: status_in = ST_STOPPED;
            OP_RELEASE:   status_in = ST_RELEASED;
            OP_START:     status_in = ST_STARTED;
            default:      status_in = status_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff       <= op_in;
      snd_ff      <= snd_in;
      chn_ff      <= chn_in;
      note_ff     <= note_in;
      scan_idx_ff <= scan_idx_in;
      hit_ff      <= hit_in;
      status_ff   <= status_in;
      act_idx_ff  <= act_idx_in;
   end

   // Channels beyond the configured count report idle.
   for (genvar c = 0; c < REPORTED; c++) begin : g_report
      if (c < CHANNEL_COUNT) begin : g_real
         assign reported[c] = sounds[c];
      end else begin : g_absent
         assign reported[c] = IDLE_SOUND;
      end
   end

   assign rsp.status       = status_ff;
   assign rsp.channel_used = USED_W'(act_idx_ff);
   assign rsp.chan0_sound  = reported[0];
   assign rsp.chan1_sound  = reported[1];
   assign rsp.chan2_sound  = reported[2];
   assign rsp.chan3_sound  = reported[3];

   // A response never overlaps with taking a new request.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready)
      else $error("request taken while a response is pending");

   // The block is busy in the cycle right after a request is taken.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req.ready)
      else $error("second request taken without processing the first");

   // A started sound is on the channel that the response names.
   a_start_lands: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && status_ff == ST_STARTED) |-> (sounds[act_idx_ff] == snd_ff))
      else $error("started sound missing from its channel");

   // A stop on all channels scans and then answers, never reporting a start.
   a_stop_all_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && op_ff == OP_STOP_ALL) |=> (rsp.valid
         || state_ff == S_SCAN) && !(state_ff == S_RESP && status_ff == ST_STARTED))
      else $error("stop-all sequence left the scan unexpectedly");

endmodule
